>>> hw/rtl/cfla_pkg.sv
// Shared constants, types and codes for the coalescing free list allocator.
package cfla_pkg;

   localparam int ADDR_BITS         = 20;
   localparam int LEN_BITS          = ADDR_BITS + 1;
   localparam int WIDE_BITS         = ADDR_BITS + 2;
   localparam int MAX_SEGMENTS      = 64;
   localparam int SEG_IW            = 6;
   localparam int MAX_RECORDS       = 64;
   localparam int REC_IW            = 6;
   localparam int CNT_BITS          = 7;
   localparam int PAD_BITS          = 16;
   localparam int MIN_ALIGN_LOG2    = 4;
   localparam int HEADER_BYTES      = 16;
   localparam int FREE_RECORD_BYTES = 16;
   localparam int STAT_BITS         = 32;

   localparam logic [LEN_BITS-1:0] ARENA_MAX = LEN_BITS'(1) << ADDR_BITS;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2
   } op_type;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_IGNORED    = 3'd1;
   localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
   localparam logic [2:0] ST_UNKNOWN    = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;

   typedef enum logic [4:0] {
      S_BOOT,
      S_IDLE,
      S_FIT_RD,
      S_FIT_CHK,
      S_SLOT,
      S_ACOMMIT,
      S_ASTAT,
      S_SHDN_RD,
      S_SHDN_WR,
      S_REC_RD,
      S_REC_CHK,
      S_POS_RD,
      S_POS_CHK,
      S_FREE_ACT,
      S_SHUP_RD,
      S_SHUP_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [LEN_BITS-1:0]  length;
   } seg_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] user_offset;
      logic [ADDR_BITS-1:0] padding;
      logic [LEN_BITS-1:0]  charged;
   } rec_type;

   typedef struct packed {
      logic                  fits;
      logic [PAD_BITS-1:0]   pad;
      logic [WIDE_BITS-1:0]  total;
   } fit_type;

endpackage

>>> hw/rtl/cfla_if.sv
// Request and response channel interfaces of the allocator.
interface cfla_req_if;
   import cfla_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [LEN_BITS-1:0]  request_bytes;
   logic [3:0]           alignment_log2;
   logic [ADDR_BITS-1:0] block_offset;
   modport source (output valid, req_type, request_bytes, alignment_log2, block_offset,
                   input ready);
   modport sink (input valid, req_type, request_bytes, alignment_log2, block_offset,
                 output ready);
endinterface

interface cfla_rsp_if;
   import cfla_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [2:0]           status;
   logic [ADDR_BITS-1:0] result_offset;
   logic [LEN_BITS-1:0]  charged_bytes;
   logic [LEN_BITS-1:0]  used_bytes;
   logic [LEN_BITS-1:0]  peak_used_bytes;
   logic [CNT_BITS-1:0]  live_allocations;
   logic [CNT_BITS-1:0]  free_segments;
   logic [STAT_BITS-1:0] waste_bytes;
   logic [STAT_BITS-1:0] allocs_total;
   logic [STAT_BITS-1:0] frees_total;
   modport source (output valid, status, result_offset, charged_bytes, used_bytes,
                   peak_used_bytes, live_allocations, free_segments, waste_bytes,
                   allocs_total, frees_total, input ready);
   modport sink (input valid, status, result_offset, charged_bytes, used_bytes,
                 peak_used_bytes, live_allocations, free_segments, waste_bytes,
                 allocs_total, frees_total, output ready);
endinterface

>>> hw/rtl/cfla_ram.sv
// Simple dual port RAM with registered read data.
module cfla_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 41
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/cfla_fit.sv
// Fit unit: aligned padding and total size of an allocation within one segment.
module cfla_fit (
   input  cfla_pkg::seg_type                  seg,
   input  logic [cfla_pkg::LEN_BITS-1:0]      bytes,
   input  logic [3:0]                         alog,
   output cfla_pkg::fit_type                  fit
);
   import cfla_pkg::*;

   logic [3:0]           shift;
   logic [WIDE_BITS-1:0] amask;
   logic [WIDE_BITS-1:0] base;
   logic [WIDE_BITS-1:0] up;
   logic [WIDE_BITS-1:0] pad;
   logic [WIDE_BITS-1:0] total;

   always_comb begin
      shift = (alog < 4'(MIN_ALIGN_LOG2)) ? 4'(MIN_ALIGN_LOG2) : alog;
      amask = (WIDE_BITS'(1) << shift) - WIDE_BITS'(1);
      base  = WIDE_BITS'(seg.start) + WIDE_BITS'(HEADER_BYTES);
      up    = (base + amask) & ~amask;
      pad   = up - WIDE_BITS'(seg.start);
      total = pad + WIDE_BITS'(bytes);
      fit.pad   = pad[PAD_BITS-1:0];
      fit.total = total;
      fit.fits  = WIDE_BITS'(seg.length) >= total;
   end
endmodule

>>> hw/rtl/coalescing_free_list_allocator.sv
// Best fit free list allocator with coalescing over an address ordered segment table.
// Allocate scans segments for the best fit, then record slots, then may shift entries;
//   free searches records, then segment positions, then may shift entries.
// Throughput: one request at a time; ready only while idle. The segment and record
//   RAMs with one read and one write port per cycle set the pace.
// Reset: synchronous; the boot state writes the full arena segment before first ready.
module coalescing_free_list_allocator (
   input  logic                         clock,
   input  logic                         reset,
   cfla_req_if.sink                     req,
   cfla_rsp_if.source                   rsp,
   input  logic                         csr_we,
   input  logic [cfla_pkg::LEN_BITS-1:0] csr_wdata
);
   import cfla_pkg::*;

   state_type state_ff, state_in;

   logic [LEN_BITS-1:0]  arena_ff;
   logic [1:0]           op_ff, op_in;
   logic [LEN_BITS-1:0]  bytes_ff, bytes_in;
   logic [3:0]           alog_ff, alog_in;
   logic [ADDR_BITS-1:0] off_ff, off_in;
   logic [CNT_BITS-1:0]  i_ff, i_in;
   logic [CNT_BITS-1:0]  j_ff, j_in;
   logic                 found_ff, found_in;
   logic [SEG_IW-1:0]    best_ff, best_in;
   logic [PAD_BITS-1:0]  best_pad_ff, best_pad_in;
   logic [WIDE_BITS-1:0] best_tot_ff, best_tot_in;
   seg_type              best_seg_ff, best_seg_in;
   logic                 split_ff, split_in;
   logic [REC_IW-1:0]    rec_ff, rec_in;
   seg_type              prev_ff, prev_in;
   seg_type              next_ff, next_in;
   logic                 next_ok_ff, next_ok_in;
   logic [ADDR_BITS-1:0] fstart_ff, fstart_in;
   logic [LEN_BITS-1:0]  flen_ff, flen_in;
   logic [2:0]           status_ff, status_in;
   logic [ADDR_BITS-1:0] roff_ff, roff_in;
   logic [LEN_BITS-1:0]  charged_ff, charged_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [LEN_BITS-1:0]  used_ff, used_in;
   logic [LEN_BITS-1:0]  peak_ff, peak_in;
   logic [CNT_BITS-1:0]  live_ff, live_in;
   logic [STAT_BITS-1:0] waste_ff, waste_in;
   logic [STAT_BITS-1:0] allocs_ff, allocs_in;
   logic [STAT_BITS-1:0] frees_ff, frees_in;
   logic [MAX_RECORDS-1:0] rv_ff, rv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 load_rsp;

   logic                 seg_we;
   logic [SEG_IW-1:0]    seg_waddr, seg_raddr;
   seg_type              seg_wdata, seg_rdata;
   logic                 rec_we;
   logic [REC_IW-1:0]    rec_waddr, rec_raddr;
   rec_type              rec_wdata, rec_rdata;
   fit_type              fit;

   logic [LEN_BITS-1:0]  rem;
   logic [WIDE_BITS-1:0] split_at;
   logic [2:0]           split_pad;
   logic                 do_split;
   logic [LEN_BITS-1:0]  a_charged;
   logic                 nx, pv;
   logic [LEN_BITS-1:0]  used_sum;

   cfla_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH($bits(seg_type))) u_seg_ram (
      .clock (clock),
      .we    (seg_we),
      .waddr (seg_waddr),
      .wdata (seg_wdata),
      .raddr (seg_raddr),
      .rdata (seg_rdata)
   );

   cfla_ram #(.DEPTH(MAX_RECORDS), .WIDTH($bits(rec_type))) u_rec_ram (
      .clock (clock),
      .we    (rec_we),
      .waddr (rec_waddr),
      .wdata (rec_wdata),
      .raddr (rec_raddr),
      .rdata (rec_rdata)
   );

   cfla_fit u_fit (
      .seg   (seg_rdata),
      .bytes (bytes_ff),
      .alog  (alog_ff),
      .fit   (fit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         arena_ff     <= ARENA_MAX;
         count_ff     <= CNT_BITS'(1);
         used_ff      <= '0;
         peak_ff      <= '0;
         live_ff      <= '0;
         waste_ff     <= '0;
         allocs_ff    <= '0;
         frees_ff     <= '0;
         rv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            arena_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         live_ff      <= live_in;
         waste_ff     <= waste_in;
         allocs_ff    <= allocs_in;
         frees_ff     <= frees_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bytes_ff    <= bytes_in;
      alog_ff     <= alog_in;
      off_ff      <= off_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_pad_ff <= best_pad_in;
      best_tot_ff <= best_tot_in;
      best_seg_ff <= best_seg_in;
      split_ff    <= split_in;
      rec_ff      <= rec_in;
      prev_ff     <= prev_in;
      next_ff     <= next_in;
      next_ok_ff  <= next_ok_in;
      fstart_ff   <= fstart_in;
      flen_ff     <= flen_in;
      status_ff   <= status_in;
      roff_ff     <= roff_in;
      charged_ff  <= charged_in;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp.status           <= status_ff;
         rsp.result_offset    <= roff_ff;
         rsp.charged_bytes    <= charged_ff;
         rsp.used_bytes       <= used_ff;
         rsp.peak_used_bytes  <= peak_ff;
         rsp.live_allocations <= live_ff;
         rsp.free_segments    <= count_ff;
         rsp.waste_bytes      <= waste_ff;
         rsp.allocs_total     <= allocs_ff;
         rsp.frees_total      <= frees_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      rem       = LEN_BITS'(WIDE_BITS'(best_seg_ff.length) - best_tot_ff);
      split_at  = WIDE_BITS'(best_seg_ff.start) + best_tot_ff;
      split_pad = 3'(~split_at[2:0] + 3'd1);
      do_split  = WIDE_BITS'(rem) >=
                  WIDE_BITS'(split_pad) + WIDE_BITS'(FREE_RECORD_BYTES + 1);
      a_charged = do_split ? LEN_BITS'(best_tot_ff + WIDE_BITS'(split_pad))
                           : best_seg_ff.length;
      nx = next_ok_ff &&
           (WIDE_BITS'(fstart_ff) + WIDE_BITS'(flen_ff) == WIDE_BITS'(next_ff.start));
      pv = (i_ff != '0) &&
           (WIDE_BITS'(prev_ff.start) + WIDE_BITS'(prev_ff.length) == WIDE_BITS'(fstart_ff));
      used_sum = used_ff + charged_ff;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      bytes_in     = bytes_ff;
      alog_in      = alog_ff;
      off_in       = off_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_pad_in  = best_pad_ff;
      best_tot_in  = best_tot_ff;
      best_seg_in  = best_seg_ff;
      split_in     = split_ff;
      rec_in       = rec_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      next_ok_in   = next_ok_ff;
      fstart_in    = fstart_ff;
      flen_in      = flen_ff;
      status_in    = status_ff;
      roff_in      = roff_ff;
      charged_in   = charged_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      peak_in      = peak_ff;
      live_in      = live_ff;
      waste_in     = waste_ff;
      allocs_in    = allocs_ff;
      frees_in     = frees_ff;
      rv_in        = rv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      load_rsp     = 1'b0;
      seg_we       = 1'b0;
      seg_waddr    = '0;
      seg_wdata    = '0;
      seg_raddr    = i_ff[SEG_IW-1:0];
      rec_we       = 1'b0;
      rec_waddr    = rec_ff;
      rec_wdata    = '0;
      rec_raddr    = i_ff[REC_IW-1:0];

      case (state_ff)
         S_BOOT: begin
            seg_we           = 1'b1;
            seg_wdata.start  = '0;
            seg_wdata.length = ARENA_MAX;
            state_in         = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               op_in      = req.req_type;
               bytes_in   = req.request_bytes;
               alog_in    = req.alignment_log2;
               off_in     = req.block_offset;
               roff_in    = '0;
               charged_in = '0;
               i_in       = '0;
               found_in   = 1'b0;
               status_in  = ST_IGNORED;
               state_in   = S_DONE;
               case (op_type'(req.req_type))
                  OP_ALLOC: begin
                     if (req.request_bytes != '0) begin
                        state_in = S_FIT_RD;
                     end
                  end
                  OP_FREE: begin
                     if (req.block_offset != '0) begin
                        state_in = S_REC_RD;
                     end
                  end
                  OP_INIT: begin
                     seg_we           = 1'b1;
                     seg_wdata.start  = '0;
                     seg_wdata.length = (arena_ff > ARENA_MAX) ? ARENA_MAX : arena_ff;
                     count_in         = CNT_BITS'(1);
                     used_in          = '0;
                     live_in          = '0;
                     waste_in         = '0;
                     rv_in            = '0;
                     status_in        = ST_OK;
                  end
                  default: begin
                     status_in = ST_IGNORED;
                  end
               endcase
            end
         end
         S_FIT_RD: begin
            if (i_ff == count_ff) begin
               i_in = '0;
               if (found_ff) begin
                  state_in = S_SLOT;
               end else begin
                  status_in = ST_EXHAUSTED;
                  state_in  = S_DONE;
               end
            end else begin
               state_in = S_FIT_CHK;
            end
         end
         S_FIT_CHK: begin
            if (fit.fits && (!found_ff || fit.total < best_tot_ff)) begin
               found_in    = 1'b1;
               best_in     = i_ff[SEG_IW-1:0];
               best_pad_in = fit.pad;
               best_tot_in = fit.total;
               best_seg_in = seg_rdata;
            end
            i_in     = i_ff + CNT_BITS'(1);
            state_in = S_FIT_RD;
         end
         S_SLOT: begin
            if (i_ff == CNT_BITS'(MAX_RECORDS)) begin
               status_in = ST_TABLE_FULL;
               state_in  = S_DONE;
            end else if (!rv_ff[i_ff[REC_IW-1:0]]) begin
               rec_in   = i_ff[REC_IW-1:0];
               state_in = S_ACOMMIT;
            end else begin
               i_in = i_ff + CNT_BITS'(1);
            end
         end
         S_ACOMMIT: begin
            roff_in               = ADDR_BITS'(WIDE_BITS'(best_seg_ff.start) +
                                                WIDE_BITS'(best_pad_ff));
            charged_in            = a_charged;
            split_in              = do_split;
            status_in             = ST_OK;
            rec_we                = 1'b1;
            rec_wdata.user_offset = ADDR_BITS'(WIDE_BITS'(best_seg_ff.start) +
                                                WIDE_BITS'(best_pad_ff));
            rec_wdata.padding     = ADDR_BITS'(best_pad_ff);
            rec_wdata.charged     = a_charged;
            rv_in[rec_ff]         = 1'b1;
            waste_in              = waste_ff + STAT_BITS'(best_pad_ff) -
                                    STAT_BITS'(HEADER_BYTES);
            if (do_split) begin
               seg_we           = 1'b1;
               seg_waddr        = best_ff;
               seg_wdata.start  = ADDR_BITS'(split_at + WIDE_BITS'(split_pad));
               seg_wdata.length = rem - LEN_BITS'(split_pad);
            end
            state_in = S_ASTAT;
         end
         S_ASTAT: begin
            used_in   = used_sum;
            if (used_sum > peak_ff) begin
               peak_in = used_sum;
            end
            live_in   = live_ff + CNT_BITS'(1);
            allocs_in = allocs_ff + STAT_BITS'(1);
            if (split_ff) begin
               state_in = S_DONE;
            end else begin
               count_in = count_ff - CNT_BITS'(1);
               j_in     = CNT_BITS'(best_ff);
               state_in = S_SHDN_RD;
            end
         end
         S_SHDN_RD: begin
            seg_raddr = SEG_IW'(j_ff + CNT_BITS'(1));
            if (j_ff >= count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SHDN_WR;
            end
         end
         S_SHDN_WR: begin
            seg_we    = 1'b1;
            seg_waddr = j_ff[SEG_IW-1:0];
            seg_wdata = seg_rdata;
            j_in      = j_ff + CNT_BITS'(1);
            state_in  = S_SHDN_RD;
         end
         S_REC_RD: begin
            if (i_ff == CNT_BITS'(MAX_RECORDS)) begin
               status_in = ST_UNKNOWN;
               state_in  = S_DONE;
            end else begin
               state_in = S_REC_CHK;
            end
         end
         S_REC_CHK: begin
            if (rv_ff[i_ff[REC_IW-1:0]] && rec_rdata.user_offset == off_ff) begin
               rec_in     = i_ff[REC_IW-1:0];
               fstart_in  = off_ff - rec_rdata.padding;
               flen_in    = rec_rdata.charged;
               i_in       = '0;
               next_ok_in = 1'b0;
               state_in   = S_POS_RD;
            end else begin
               i_in     = i_ff + CNT_BITS'(1);
               state_in = S_REC_RD;
            end
         end
         S_POS_RD: begin
            if (i_ff == count_ff) begin
               state_in = S_FREE_ACT;
            end else begin
               state_in = S_POS_CHK;
            end
         end
         S_POS_CHK: begin
            if (seg_rdata.start < fstart_ff) begin
               prev_in  = seg_rdata;
               i_in     = i_ff + CNT_BITS'(1);
               state_in = S_POS_RD;
            end else begin
               next_in    = seg_rdata;
               next_ok_in = 1'b1;
               state_in   = S_FREE_ACT;
            end
         end
         S_FREE_ACT: begin
            if (!nx && !pv && count_ff >= CNT_BITS'(MAX_SEGMENTS)) begin
               status_in = ST_TABLE_FULL;
               state_in  = S_DONE;
            end else begin
               status_in     = ST_OK;
               charged_in    = flen_ff;
               rv_in[rec_ff] = 1'b0;
               used_in       = used_ff - flen_ff;
               live_in       = live_ff - CNT_BITS'(1);
               frees_in      = frees_ff + STAT_BITS'(1);
               state_in      = S_DONE;
               if (nx && pv) begin
                  seg_we           = 1'b1;
                  seg_waddr        = SEG_IW'(i_ff - CNT_BITS'(1));
                  seg_wdata.start  = prev_ff.start;
                  seg_wdata.length = prev_ff.length + flen_ff + next_ff.length;
                  count_in         = count_ff - CNT_BITS'(1);
                  j_in             = i_ff;
                  state_in         = S_SHDN_RD;
               end else if (pv) begin
                  seg_we           = 1'b1;
                  seg_waddr        = SEG_IW'(i_ff - CNT_BITS'(1));
                  seg_wdata.start  = prev_ff.start;
                  seg_wdata.length = prev_ff.length + flen_ff;
               end else if (nx) begin
                  seg_we           = 1'b1;
                  seg_waddr        = i_ff[SEG_IW-1:0];
                  seg_wdata.start  = fstart_ff;
                  seg_wdata.length = flen_ff + next_ff.length;
               end else begin
                  count_in = count_ff + CNT_BITS'(1);
                  j_in     = count_ff;
                  state_in = S_SHUP_RD;
               end
            end
         end
         S_SHUP_RD: begin
            seg_raddr = SEG_IW'(j_ff - CNT_BITS'(1));
            if (j_ff == i_ff) begin
               seg_we           = 1'b1;
               seg_waddr        = i_ff[SEG_IW-1:0];
               seg_wdata.start  = fstart_ff;
               seg_wdata.length = flen_ff;
               state_in         = S_DONE;
            end else begin
               state_in = S_SHUP_WR;
            end
         end
         S_SHUP_WR: begin
            seg_we    = 1'b1;
            seg_waddr = j_ff[SEG_IW-1:0];
            seg_wdata = seg_rdata;
            j_in      = j_ff - CNT_BITS'(1);
            state_in  = S_SHUP_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_SEGMENTS))
      else $error("segment count beyond table depth");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_BITS'(MAX_RECORDS))
      else $error("live allocations beyond record depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside completion");
`endif
endmodule
